FILE: rtl/pmw_pkg.sv
// Shared types and constants for the Pledge maze walker.
// Holds action, status and heading codes, register indexes and the walk state record.
// No dependencies.
`default_nettype none

package pmw_pkg;

    // Fixed field widths.
    localparam int COORD_BITS_DEFAULT = 4;
    localparam int TURN_BITS          = 12;
    localparam int BUDGET_BITS        = 16;
    localparam int VISIT_BITS         = 3;
    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 16;

    // Limits and reset values.
    localparam logic [VISIT_BITS-1:0]  VISIT_LIMIT  = 3'd4;
    localparam logic [VISIT_BITS-1:0]  VISIT_MAX    = 3'd7;
    localparam logic [VISIT_BITS-1:0]  VISIT_FIRST  = 3'd1;
    localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 16'd768;
    localparam int                     FINISH_RESET = 15;
    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    // Item function codes.
    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FOLLOW_LEFT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_X     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_Y     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FINISH_X    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FINISH_Y    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_BUDGET = 3'd5;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_LEFT       = 3'd1,
        ACT_RIGHT      = 3'd2,
        ACT_MOVE       = 3'd3,
        ACT_LEFT_MOVE  = 3'd4,
        ACT_RIGHT_MOVE = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_RUNNING   = 2'd0,
        ST_FINISH    = 2'd1,
        ST_CYCLING   = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        HD_UP    = 2'd0,
        HD_RIGHT = 2'd1,
        HD_DOWN  = 2'd2,
        HD_LEFT  = 2'd3
    } heading_t;

    // Walk state apart from the position, whose width is a module parameter.
    typedef struct packed {
        heading_t                      heading;
        logic signed [TURN_BITS-1:0]   turns;
        logic [BUDGET_BITS-1:0]        moves;
        logic [VISIT_BITS-1:0]         visits;
        status_t                       status;
    } walk_state_t;

endpackage

`default_nettype wire

FILE: rtl/pledge_maze_walker.sv
// Pledge maze walker top level: configuration registers, walk state and result register.
// Instantiates pmw_step for the next-state logic.
// Depends on pmw_pkg and pmw_step.
//
// Usage: each input transaction on the s_ channel is either a begin (s_func = 0), which
// loads the start cell, picks a heading toward the finish and loads the move budget,
// or a step (s_func = 1), which carries three wall sensor bits for the current heading.
// Every input transaction yields exactly one result transaction on the m_ channel,
// giving the action taken, the cell and heading after it, the quarter-turn sum and
// the walk status.
// A result is registered and is valid in the cycle after its input is accepted.
// One transaction is accepted per cycle while results are taken; the walk state register
// feeds the step logic directly, so the next item sees the updated state at once.
// When the receiver stalls, the result is held in the output register and s_ready
// drops until the result is taken; s_ready stays high while the result is being taken.
// The configuration channel is always ready; registers are to be written only while the
// block is idle, which it does not enforce. Writes past the register list are ignored.
// Reset (aresetn low, synchronous) restores the register defaults, clears the walk
// state with an empty budget and empties the output register.
`default_nettype none

module pledge_maze_walker #(
    parameter int COORD_BITS = pmw_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration write channel.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pmw_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [pmw_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // Input channel.
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_func,
    input  wire logic                                  s_wall_ahead,
    input  wire logic                                  s_wall_left,
    input  wire logic                                  s_wall_right,
    // Result channel.
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [2:0]                                 m_action,
    output logic [COORD_BITS-1:0]                      m_pos_x,
    output logic [COORD_BITS-1:0]                      m_pos_y,
    output logic [1:0]                                 m_heading,
    output logic signed [pmw_pkg::TURN_BITS-1:0]       m_turn_sum,
    output logic [1:0]                                 m_status
);
    import pmw_pkg::*;

    localparam logic [COORD_BITS-1:0] FINISH_DEFAULT = COORD_BITS'(FINISH_RESET);

    logic                     follow_left_reg;
    logic [COORD_BITS-1:0]    start_x_reg, start_y_reg, finish_x_reg, finish_y_reg;
    logic [BUDGET_BITS-1:0]   budget_reg;

    logic [COORD_BITS-1:0]    x_reg, y_reg, x_next, y_next;
    walk_state_t              state_reg, state_next;
    action_t                  action_next;

    logic                     m_valid_reg;
    action_t                  m_action_reg;
    logic [COORD_BITS-1:0]    m_x_reg, m_y_reg;
    heading_t                 m_heading_reg;
    logic signed [TURN_BITS-1:0] m_turns_reg;
    status_t                  m_status_reg;

    logic in_fire;
    logic cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            follow_left_reg <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            finish_x_reg    <= FINISH_DEFAULT;
            finish_y_reg    <= FINISH_DEFAULT;
            budget_reg      <= BUDGET_RESET;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_FOLLOW_LEFT: follow_left_reg <= cfg_data[0];
                CFG_START_X:     start_x_reg     <= COORD_BITS'(cfg_data);
                CFG_START_Y:     start_y_reg     <= COORD_BITS'(cfg_data);
                CFG_FINISH_X:    finish_x_reg    <= COORD_BITS'(cfg_data);
                CFG_FINISH_Y:    finish_y_reg    <= COORD_BITS'(cfg_data);
                CFG_MOVE_BUDGET: budget_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    pmw_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .state_in    (state_reg),
        .cur_x       (x_reg),
        .cur_y       (y_reg),
        .follow_left (follow_left_reg),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .finish_x    (finish_x_reg),
        .finish_y    (finish_y_reg),
        .budget      (budget_reg),
        .func        (s_func),
        .wall_ahead  (s_wall_ahead),
        .wall_left   (s_wall_left),
        .wall_right  (s_wall_right),
        .state_out   (state_next),
        .nxt_x       (x_next),
        .nxt_y       (y_next),
        .action      (action_next)
    );

    // Walk state advances on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg            <= '0;
            y_reg            <= '0;
            state_reg.heading <= HD_UP;
            state_reg.turns  <= '0;
            state_reg.moves  <= '0;
            state_reg.visits <= VISIT_FIRST;
            state_reg.status <= ST_RUNNING;
        end else if (in_fire) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            state_reg <= state_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // Result payload, loaded with each accepted transaction.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_action_reg  <= action_next;
            m_x_reg       <= x_next;
            m_y_reg       <= y_next;
            m_heading_reg <= state_next.heading;
            m_turns_reg   <= state_next.turns;
            m_status_reg  <= state_next.status;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_action   = m_action_reg;
    assign m_pos_x    = m_x_reg;
    assign m_pos_y    = m_y_reg;
    assign m_heading  = m_heading_reg;
    assign m_turn_sum = m_turns_reg;
    assign m_status   = m_status_reg;

    // A step after the walk has ended leaves the walk state untouched.
    a_ended_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_func == FUNC_STEP && state_reg.status != ST_RUNNING
        |=> $stable(x_reg) && $stable(y_reg) && $stable(state_reg))
        else $error("walk state changed after the walk ended");

    // A begin clears the turn sum and the visit count.
    a_begin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_func == FUNC_BEGIN
        |=> state_reg.turns == '0 && state_reg.visits == VISIT_FIRST)
        else $error("begin did not clear the turn sum or visits");

    // The budget only shrinks during steps, and by at most one.
    a_budget_down: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_func == FUNC_STEP
        |=> state_reg.moves == $past(state_reg.moves)
            || state_reg.moves == $past(state_reg.moves) - 1'b1)
        else $error("move budget changed by more than one move");

    // The result register reflects the state written with it.
    a_result_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_valid && m_pos_x == x_reg && m_pos_y == y_reg
            && m_status == state_reg.status)
        else $error("result does not match the walk state");

    // The visit count never falls to zero.
    a_visits_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.visits != '0)
        else $error("start visit count is zero");

endmodule

`default_nettype wire

FILE: rtl/pmw_step.sv
// Next-state logic of the Pledge maze walker for one transaction.
// Purely combinational: begin handling, wall-following decision, move and status checks.
// Depends on pmw_pkg.
`default_nettype none

module pmw_step #(
    parameter int COORD_BITS = pmw_pkg::COORD_BITS_DEFAULT
) (
    input  wire pmw_pkg::walk_state_t      state_in,
    input  wire logic [COORD_BITS-1:0]     cur_x,
    input  wire logic [COORD_BITS-1:0]     cur_y,
    input  wire logic                      follow_left,
    input  wire logic [COORD_BITS-1:0]     start_x,
    input  wire logic [COORD_BITS-1:0]     start_y,
    input  wire logic [COORD_BITS-1:0]     finish_x,
    input  wire logic [COORD_BITS-1:0]     finish_y,
    input  wire logic [pmw_pkg::BUDGET_BITS-1:0] budget,
    input  wire logic                      func,
    input  wire logic                      wall_ahead,
    input  wire logic                      wall_left,
    input  wire logic                      wall_right,
    output pmw_pkg::walk_state_t           state_out,
    output logic [COORD_BITS-1:0]          nxt_x,
    output logic [COORD_BITS-1:0]          nxt_y,
    output pmw_pkg::action_t               action
);
    import pmw_pkg::*;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        ax, ay;
    heading_t                   init_heading;
    logic                       do_left, do_right, do_move;
    heading_t                   hd_turned;
    logic signed [TURN_BITS-1:0] turns_turned;
    logic [COORD_BITS-1:0]      mx, my;
    logic [VISIT_BITS-1:0]      visits_moved;
    logic [BUDGET_BITS-1:0]     moves_moved;

    // Initial heading points toward the finish; ties go horizontal.
    assign dx = $signed({1'b0, finish_x}) - $signed({1'b0, start_x});
    assign dy = $signed({1'b0, finish_y}) - $signed({1'b0, start_y});
    assign ax = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
    assign ay = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);

    always_comb begin
        if (ay > ax) begin
            init_heading = dy[COORD_BITS] ? HD_UP : HD_DOWN;
        end else begin
            init_heading = dx[COORD_BITS] ? HD_LEFT : HD_RIGHT;
        end
    end

    // Wall-following decision for a step while the walk runs.
    always_comb begin
        do_left  = 1'b0;
        do_right = 1'b0;
        do_move  = 1'b0;
        action   = ACT_NONE;
        if (func == FUNC_STEP && state_in.status == ST_RUNNING && state_in.moves != '0) begin
            if (follow_left) begin
                if (state_in.turns != '0 && !wall_left) begin
                    do_left = 1'b1;
                    do_move = 1'b1;
                    action  = ACT_LEFT_MOVE;
                end else if (!wall_ahead) begin
                    do_move = 1'b1;
                    action  = ACT_MOVE;
                end else begin
                    do_right = 1'b1;
                    action   = ACT_RIGHT;
                end
            end else begin
                if (state_in.turns != '0 && !wall_right) begin
                    do_right = 1'b1;
                    do_move  = 1'b1;
                    action   = ACT_RIGHT_MOVE;
                end else if (!wall_ahead) begin
                    do_move = 1'b1;
                    action  = ACT_MOVE;
                end else begin
                    do_left = 1'b1;
                    action  = ACT_LEFT;
                end
            end
        end
    end

    // Turn in place with a saturating quarter-turn sum.
    always_comb begin
        hd_turned    = state_in.heading;
        turns_turned = state_in.turns;
        if (do_left) begin
            hd_turned = heading_t'(state_in.heading - 2'd1);
            if (state_in.turns != TURN_MAX) begin
                turns_turned = state_in.turns + 12'sd1;
            end
        end else if (do_right) begin
            hd_turned = heading_t'(state_in.heading + 2'd1);
            if (state_in.turns != TURN_MIN) begin
                turns_turned = state_in.turns - 12'sd1;
            end
        end
    end

    // One cell along the new heading, held at the grid edges.
    always_comb begin
        mx = cur_x;
        my = cur_y;
        case (hd_turned)
            HD_UP:    if (cur_y != '0)       my = cur_y - 1'b1;
            HD_RIGHT: if (cur_x != COORD_MAX) mx = cur_x + 1'b1;
            HD_DOWN:  if (cur_y != COORD_MAX) my = cur_y + 1'b1;
            default:  if (cur_x != '0)       mx = cur_x - 1'b1;
        endcase
    end

    assign visits_moved = (mx == start_x && my == start_y && state_in.visits < VISIT_MAX) ?
                          state_in.visits + 1'b1 : state_in.visits;
    assign moves_moved  = state_in.moves - 1'b1;

    // Select the next state.
    always_comb begin
        state_out = state_in;
        nxt_x     = cur_x;
        nxt_y     = cur_y;
        if (func == FUNC_BEGIN) begin
            nxt_x             = start_x;
            nxt_y             = start_y;
            state_out.heading = init_heading;
            state_out.turns   = '0;
            state_out.moves   = budget;
            state_out.visits  = VISIT_FIRST;
            state_out.status  = (budget == '0) ? ST_EXHAUSTED : ST_RUNNING;
        end else if (state_in.status != ST_RUNNING) begin
            state_out = state_in;
        end else if (state_in.moves == '0) begin
            state_out.status = ST_EXHAUSTED;
        end else begin
            state_out.heading = hd_turned;
            state_out.turns   = turns_turned;
            if (do_move) begin
                nxt_x            = mx;
                nxt_y            = my;
                state_out.visits = visits_moved;
                state_out.moves  = moves_moved;
                if (visits_moved > VISIT_LIMIT) begin
                    state_out.status = ST_CYCLING;
                end else if (mx == finish_x && my == finish_y) begin
                    state_out.status = ST_FINISH;
                end else if (moves_moved == '0) begin
                    state_out.status = ST_EXHAUSTED;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_pledge_maze_walker.sv
// Self-checking testbench for the Pledge maze walker: directed walks, turn-sum spins
// and random walks, each result checked against an in-bench walk predictor.
// Depends on pmw_pkg and pledge_maze_walker.
`default_nettype none

module tb_pledge_maze_walker;
    import pmw_pkg::*;

    localparam int CB          = COORD_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int WALK_ITEMS  = 400;
    localparam int SPIN_STEPS  = 40;
    localparam int MAX_REPORTS = 10;

    // Indexes past the end of the register list; writes to them must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

    localparam logic [CB-1:0] EDGE_MAX = '1;

    // One expected result transaction.
    typedef struct {
        action_t                     action;
        logic [CB-1:0]               x;
        logic [CB-1:0]               y;
        heading_t                    heading;
        logic signed [TURN_BITS-1:0] turns;
        status_t                     status;
    } walk_result_t;

    // Walk predictor and store of expected results.
    class walk_scoreboard;
        bit                          follow_left;
        logic [CB-1:0]               start_x, start_y, finish_x, finish_y;
        logic [BUDGET_BITS-1:0]      budget;
        logic [CB-1:0]               cx, cy;
        heading_t                    cur_hd;
        logic signed [TURN_BITS-1:0] turns;
        logic [BUDGET_BITS-1:0]      moves_left;
        logic [VISIT_BITS-1:0]       visits;
        status_t                     walk_st;
        walk_result_t                expected_q[$];
        int                          errors;

        function new();
            follow_left = 1'b0;
            start_x     = '0;
            start_y     = '0;
            finish_x    = EDGE_MAX;
            finish_y    = EDGE_MAX;
            budget      = BUDGET_RESET;
            cx          = '0;
            cy          = '0;
            cur_hd      = HD_UP;
            turns       = '0;
            moves_left  = '0;
            visits      = VISIT_FIRST;
            walk_st     = ST_RUNNING;
            errors      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_FOLLOW_LEFT: follow_left = data[0];
                CFG_START_X:     start_x     = data[CB-1:0];
                CFG_START_Y:     start_y     = data[CB-1:0];
                CFG_FINISH_X:    finish_x    = data[CB-1:0];
                CFG_FINISH_Y:    finish_y    = data[CB-1:0];
                CFG_MOVE_BUDGET: budget      = data;
                default: ;
            endcase
        endfunction

        // Heading toward the finish; ties go horizontal.
        function heading_t first_heading();
            int dx, dy, ax, ay;
            dx = int'(finish_x) - int'(start_x);
            dy = int'(finish_y) - int'(start_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ay > ax)
                return (dy < 0) ? HD_UP : HD_DOWN;
            return (dx < 0) ? HD_LEFT : HD_RIGHT;
        endfunction

        // Quarter turn in place with a saturating turn sum.
        function void rotate(bit to_left);
            logic [1:0] h;
            int t;
            h      = cur_hd;
            h      = to_left ? h - 2'd1 : h + 2'd1;
            cur_hd = heading_t'(h);
            t      = int'(turns) + (to_left ? 1 : -1);
            if (t > TURN_MAX) t = TURN_MAX;
            if (t < TURN_MIN) t = TURN_MIN;
            turns = TURN_BITS'(t);
        endfunction

        // One cell forward, held at the grid edge, then the end-of-walk checks.
        function void step_cell();
            case (cur_hd)
                HD_UP:    if (cy != '0) cy = cy - 1'b1;
                HD_RIGHT: if (cx != EDGE_MAX) cx = cx + 1'b1;
                HD_DOWN:  if (cy != EDGE_MAX) cy = cy + 1'b1;
                default:  if (cx != '0) cx = cx - 1'b1;
            endcase
            if (cx == start_x && cy == start_y && visits < VISIT_MAX)
                visits = visits + 1'b1;
            if (moves_left != '0)
                moves_left = moves_left - 1'b1;
            if (visits > VISIT_LIMIT)
                walk_st = ST_CYCLING;
            else if (cx == finish_x && cy == finish_y)
                walk_st = ST_FINISH;
            else if (moves_left == '0)
                walk_st = ST_EXHAUSTED;
        endfunction

        // Note an accepted input transaction and queue the result it must produce.
        function void note_item(logic func, logic ahead, logic lwall, logic rwall);
            walk_result_t r;
            r.action = ACT_NONE;
            if (func == FUNC_BEGIN) begin
                cx         = start_x;
                cy         = start_y;
                cur_hd     = first_heading();
                turns      = '0;
                moves_left = budget;
                visits     = VISIT_FIRST;
                walk_st    = (budget == '0) ? ST_EXHAUSTED : ST_RUNNING;
            end else if (walk_st != ST_RUNNING) begin
                r.action = ACT_NONE;
            end else if (moves_left == '0) begin
                walk_st = ST_EXHAUSTED;
            end else if (follow_left) begin
                if (turns != 0 && !lwall) begin
                    rotate(1'b1);
                    step_cell();
                    r.action = ACT_LEFT_MOVE;
                end else if (!ahead) begin
                    step_cell();
                    r.action = ACT_MOVE;
                end else begin
                    rotate(1'b0);
                    r.action = ACT_RIGHT;
                end
            end else begin
                if (turns != 0 && !rwall) begin
                    rotate(1'b0);
                    step_cell();
                    r.action = ACT_RIGHT_MOVE;
                end else if (!ahead) begin
                    step_cell();
                    r.action = ACT_MOVE;
                end else begin
                    rotate(1'b1);
                    r.action = ACT_LEFT;
                end
            end
            r.x       = cx;
            r.y       = cy;
            r.heading = cur_hd;
            r.turns   = turns;
            r.status  = walk_st;
            expected_q.push_back(r);
        endfunction

        // Compare an accepted result transaction with the oldest expectation.
        function void check_result(logic [2:0] act, logic [CB-1:0] x, logic [CB-1:0] y,
                                   logic [1:0] hd, logic signed [TURN_BITS-1:0] ts,
                                   logic [1:0] st);
            walk_result_t e;
            bit ok;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: result act=%0d x=%0d y=%0d with nothing pending",
                             act, x, y);
                return;
            end
            e  = expected_q.pop_front();
            ok = 1'b1;
            if (act !== e.action)  ok = 1'b0;
            if (x   !== e.x)       ok = 1'b0;
            if (y   !== e.y)       ok = 1'b0;
            if (hd  !== e.heading) ok = 1'b0;
            if (ts  !== e.turns)   ok = 1'b0;
            if (st  !== e.status)  ok = 1'b0;
            if (!ok) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $write("mismatch: expected act=%0d x=%0d y=%0d hd=%0d sum=%0d st=%0d,",
                           e.action, e.x, e.y, e.heading, e.turns, e.status);
                    $display(" got act=%0d x=%0d y=%0d hd=%0d sum=%0d st=%0d",
                             act, x, y, hd, ts, st);
                end
            end
        endfunction
    endclass

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data     = '0;
    logic                        s_valid      = 1'b0;
    logic                        s_ready;
    logic                        s_func       = 1'b0;
    logic                        s_wall_ahead = 1'b0;
    logic                        s_wall_left  = 1'b0;
    logic                        s_wall_right = 1'b0;
    logic                        m_valid;
    logic                        m_ready      = 1'b0;
    logic [2:0]                  m_action;
    logic [CB-1:0]               m_pos_x;
    logic [CB-1:0]               m_pos_y;
    logic [1:0]                  m_heading;
    logic signed [TURN_BITS-1:0] m_turn_sum;
    logic [1:0]                  m_status;

    walk_scoreboard sb = new();
    bit             calm         = 1'b0;
    bit             hold_request = 1'b0;
    int             cycles       = 0;
    int             items_sent   = 0;

    pledge_maze_walker #(.COORD_BITS(CB)) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_wall_ahead (s_wall_ahead),
        .s_wall_left  (s_wall_left),
        .s_wall_right (s_wall_right),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_action     (m_action),
        .m_pos_x      (m_pos_x),
        .m_pos_y      (m_pos_y),
        .m_heading    (m_heading),
        .m_turn_sum   (m_turn_sum),
        .m_status     (m_status)
    );

    // Clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Check every result transaction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_action, m_pos_x, m_pos_y, m_heading, m_turn_sum, m_status);
    end

    // Idle length: mostly none, often short, sometimes long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_ready <= 1'b1;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Offer one input transaction and hold it until accepted.
    task automatic send_item(logic func, logic ahead, logic lwall, logic rwall);
        int gap;
        s_func       <= func;
        s_wall_ahead <= ahead;
        s_wall_left  <= lwall;
        s_wall_right <= rwall;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(func, ahead, lwall, rwall);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic step(logic ahead, logic lwall, logic rwall);
        send_item(FUNC_STEP, ahead, lwall, rwall);
    endtask

    // Begin a walk; the wall bits are ignored, so they are random.
    task automatic begin_walk();
        send_item(FUNC_BEGIN, 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // One configuration transaction; the caller lowers cfg_valid after the batch.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // Program every register while idle. Unused upper data bits carry noise.
    task automatic program_walk(bit fl, logic [CB-1:0] sx, logic [CB-1:0] sy,
                                logic [CB-1:0] fx, logic [CB-1:0] fy,
                                logic [BUDGET_BITS-1:0] bud);
        drain();
        write_reg(CFG_FOLLOW_LEFT, {15'($urandom), fl});
        write_reg(CFG_START_X,     {12'($urandom), sx});
        write_reg(CFG_START_Y,     {12'($urandom), sy});
        write_reg(CFG_FINISH_X,    {12'($urandom), fx});
        write_reg(CFG_FINISH_Y,    {12'($urandom), fy});
        if ($urandom_range(0, 5) == 0)
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, 16'($urandom));
        write_reg(CFG_MOVE_BUDGET, bud);
        cfg_valid <= 1'b0;
    endtask

    // Coordinates lean toward the grid edges.
    function automatic logic [CB-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return '0;
        if (r < 4) return EDGE_MAX;
        return CB'($urandom_range(0, 15));
    endfunction

    function automatic logic [CB-1:0] near_or_far(logic [CB-1:0] c);
        if ($urandom_range(0, 1))
            return c + CB'($urandom_range(0, 4)) - CB'(2);
        return pick_coord();
    endfunction

    function automatic logic [BUDGET_BITS-1:0] pick_budget();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return 16'd1;
        return BUDGET_BITS'($urandom_range(2, 48));
    endfunction

    // A walk with random sensors, now and then broken by a fresh begin.
    task automatic random_walk();
        logic [CB-1:0] sx, sy;
        int            n;
        sx   = pick_coord();
        sy   = pick_coord();
        calm = ($urandom_range(0, 3) == 0);
        program_walk(1'($urandom_range(0, 1)), sx, sy, near_or_far(sx), near_or_far(sy),
                     pick_budget());
        begin_walk();
        n = 0;
        while (sb.walk_st == ST_RUNNING && n < 60) begin
            if ($urandom_range(0, 11) == 0)
                begin_walk();
            else
                step($urandom_range(0, 9) < 4, 1'($urandom), 1'($urandom));
            n++;
        end
        // Steps after the walk has ended change nothing.
        repeat ($urandom_range(0, 2)) step(1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Turn in place for a while so the turn sum runs away from zero.
    // With hold set, the receiver holds off while the turns are offered.
    task automatic spin_walk(bit fl, bit hold);
        program_walk(fl, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     BUDGET_BITS'($urandom_range(2, 48)));
        begin_walk();
        if (hold)
            hold_request = 1'b1;
        repeat (SPIN_STEPS) begin
            if (fl)
                step(1'b1, 1'b1, 1'($urandom));
            else
                step(1'b1, 1'($urandom), 1'b1);
        end
        repeat (4) step(1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Main sequence.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // A step before any begin finds no budget.
        step(1'b0, 1'b0, 1'b0);

        // Left wall, tie toward the finish: move, turn right, then turn left and move.
        program_walk(1'b1, 4'd0, 4'd0, 4'd15, 4'd15, 16'd768);
        begin_walk();
        step(1'b0, 1'b1, 1'b1);
        step(1'b1, 1'b1, 1'b1);
        step(1'b1, 1'b0, 1'b1);

        // Right wall heading up with a budget of three, then a step after the end.
        program_walk(1'b0, 4'd5, 4'd10, 4'd5, 4'd2, 16'd3);
        begin_walk();
        step(1'b1, 1'b1, 1'b1);
        step(1'b1, 1'b1, 1'b0);
        step(1'b0, 1'b1, 1'b1);
        step(1'b0, 1'b0, 1'b0);
        step(1'b0, 1'b0, 1'b0);

        // Initial heading left with the largest budget.
        program_walk(1'b1, 4'd10, 4'd3, 4'd2, 4'd3, 16'hFFFF);
        begin_walk();
        step(1'b1, 1'b1, 1'b1);

        // Initial heading down with a single move.
        program_walk(1'b0, 4'd3, 4'd2, 4'd3, 4'd9, 16'd1);
        begin_walk();
        step(1'b0, 1'b0, 1'b0);

        // Zero budget with start on the finish.
        program_walk(1'b0, 4'd7, 4'd7, 4'd7, 4'd7, 16'd0);
        begin_walk();
        step(1'b0, 1'b0, 1'b0);

        // One move onto the finish.
        program_walk(1'b1, 4'd0, 4'd0, 4'd1, 4'd0, 16'd768);
        begin_walk();
        step(1'b0, 1'b0, 1'b0);

        // Bump into the top edge on the start cell until cycling is reported.
        program_walk(1'b0, 4'd0, 4'd0, 4'd15, 4'd15, 16'd768);
        begin_walk();
        step(1'b1, 1'b0, 1'b0);
        repeat (4) step(1'b0, 1'b1, 1'b1);

        // Both turn directions; the receiver holds off during the first spin.
        spin_walk(1'b1, 1'b1);
        spin_walk(1'b0, 1'b0);

        while (items_sent < WALK_ITEMS)
            random_walk();

        calm = 1'b0;
        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
